/* hw/rtl/cglw_pkg.sv */
// package for the caption greedy line wrapper
// holds the beat types, field widths, scan phase codes and character codes
// no dependencies
`default_nettype none

package cglw_pkg;

   localparam int BEGIN_W = 12;
   localparam int END_W = 13;
   localparam int COLS_W = 8;
   localparam int CONSUMED_W = 13;
   localparam int LINES_W = 4;
   localparam int BYTE_W = 8;

   localparam int DEFAULT_MAX_LINES = 8;
   localparam int DEFAULT_MAX_TEXT = 4096;
   localparam logic [COLS_W-1:0] MAX_COLUMNS_RESET = 8'd40;

   localparam int RESULTS_MAX = 3;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_FILL_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] PH_SKIP = 2'd0;
   localparam logic [1:0] PH_LINE = 2'd1;
   localparam logic [1:0] PH_DONE = 2'd2;
   localparam logic [1:0] PH_DONE_BLANKS = 2'd3;

   localparam logic [BYTE_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_RETURN = 8'd13;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'd32;

   localparam logic KIND_LINE = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              final_byte;
   } req_type;

   typedef struct packed {
      logic                  record_kind;
      logic [BEGIN_W-1:0]    line_begin;
      logic [END_W-1:0]      line_end;
      logic [COLS_W-1:0]     line_columns;
      logic [CONSUMED_W-1:0] taken_bytes;
      logic                  was_truncated;
      logic [LINES_W-1:0]    lines_made;
      logic                  run_end;
   } rsp_type;

   typedef struct packed {
      logic [1:0]                  count;
      rsp_type [RESULTS_MAX-1:0]   item;
   } step_type;

   typedef struct packed {
      logic pos_zero;
   } core_status_type;

   typedef struct packed {
      logic [FIFO_FILL_W-1:0] fill;
      logic                   room;
   } fifo_status_type;

   function automatic logic is_blank(input logic [BYTE_W-1:0] c);
      return (c == CHAR_SPACE) || (c == CHAR_TAB);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/cglw_core.sv */
// wrap engine: scan state, column limit register and per-byte step logic
// depends on cglw_pkg
`default_nettype none

module cglw_core
   import cglw_pkg::*;
#(
   parameter int MAX_LINES = DEFAULT_MAX_LINES,
   parameter int MAX_TEXT = DEFAULT_MAX_TEXT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            beat,
   input  wire req_type         req_data,
   input  wire logic            csr_we,
   input  wire logic [COLS_W-1:0] csr_wdata,
   output step_type             step,
   output core_status_type      status
);

   localparam int POS_W = $clog2(MAX_TEXT + 1);
   localparam int TALLY_W = $clog2(MAX_LINES + 1);
   localparam logic [POS_W-1:0] TEXT_LIMIT = POS_W'(MAX_TEXT);
   localparam logic [TALLY_W-1:0] LINE_LIMIT = TALLY_W'(MAX_LINES);

   logic [COLS_W-1:0]  max_columns_ff;
   logic [COLS_W-1:0]  limit_ff, limit_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [1:0]         phase_ff, phase_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [COLS_W-1:0]  tally_ff, tally_in;
   logic [POS_W-1:0]   bsi_ff, bsi_in;
   logic               bsv_ff, bsv_in;
   logic [COLS_W-1:0]  cas_ff, cas_in;
   logic [POS_W-1:0]   vebs_ff, vebs_in;
   logic [COLS_W-1:0]  vcbs_ff, vcbs_in;
   logic [POS_W-1:0]   lve_ff, lve_in;
   logic [COLS_W-1:0]  lvc_ff, lvc_in;
   logic [TALLY_W-1:0] lines_ff, lines_in;
   logic [POS_W-1:0]   cons_ff, cons_in;
   logic               cut_ff, cut_in;

   function automatic rsp_type make_line(input logic [POS_W-1:0] b,
                                         input logic [POS_W-1:0] e,
                                         input logic [COLS_W-1:0] cols);
      rsp_type r;
      r = '0;
      r.record_kind = KIND_LINE;
      r.line_begin = BEGIN_W'(b);
      r.line_end = END_W'(e);
      r.line_columns = cols;
      return r;
   endfunction

   always_comb begin
      logic [BYTE_W-1:0] c;
      logic              blank;
      logic [POS_W-1:0]  p;
      logic [POS_W-1:0]  p_next;
      logic [POS_W-1:0]  seg;
      logic              do_line;
      logic              go;
      logic [1:0]        n;
      rsp_type [RESULTS_MAX-1:0] res;
      rsp_type           summ;

      c = req_data.text_byte;
      blank = is_blank(c);
      p = pos_ff;
      p_next = p + 1'b1;
      seg = bsi_ff + 1'b1;
      do_line = 1'b0;
      go = 1'b1;
      n = 2'd0;
      res = '0;
      summ = '0;

      limit_in = limit_ff;
      pos_in = pos_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      tally_in = tally_ff;
      bsi_in = bsi_ff;
      bsv_in = bsv_ff;
      cas_in = cas_ff;
      vebs_in = vebs_ff;
      vcbs_in = vcbs_ff;
      lve_in = lve_ff;
      lvc_in = lvc_ff;
      lines_in = lines_ff;
      cons_in = cons_ff;
      cut_in = cut_ff;

      if (p == '0) begin
         limit_in = (max_columns_ff == '0) ? COLS_W'(1) : max_columns_ff;
      end

      if (p >= TEXT_LIMIT) begin
         if (phase_ff == PH_LINE) begin
            res[n] = make_line(start_ff, lve_ff, lvc_ff);
            n = n + 1'b1;
            lines_in = lines_in + 1'b1;
            cons_in = p;
         end else if (phase_ff == PH_SKIP) begin
            cons_in = p;
         end
         cut_in = 1'b1;
         phase_in = PH_DONE;
      end else begin
         unique case (phase_ff)
            PH_SKIP: begin
               if (blank) begin
               end else if (c == CHAR_NEWLINE) begin
                  res[n] = make_line(p, p, '0);
                  n = n + 1'b1;
                  lines_in = lines_in + 1'b1;
                  if (lines_in >= LINE_LIMIT) begin
                     phase_in = PH_DONE;
                     cons_in = p_next;
                  end
               end else begin
                  phase_in = PH_LINE;
                  start_in = p;
                  tally_in = '0;
                  bsv_in = 1'b0;
                  cas_in = '0;
                  lve_in = p;
                  lvc_in = '0;
                  do_line = 1'b1;
               end
            end
            PH_LINE: begin
               do_line = 1'b1;
            end
            PH_DONE_BLANKS: begin
               if (blank) begin
                  cons_in = p_next;
               end else begin
                  cut_in = 1'b1;
                  phase_in = PH_DONE;
               end
            end
            default: begin
               cut_in = 1'b1;
            end
         endcase

         if (do_line) begin
            if (c == CHAR_NEWLINE) begin
               res[n] = make_line(start_in, lve_in, lvc_in);
               n = n + 1'b1;
               lines_in = lines_in + 1'b1;
               if (lines_in >= LINE_LIMIT) begin
                  phase_in = PH_DONE;
                  cons_in = p_next;
               end else begin
                  phase_in = PH_SKIP;
               end
            end else if (c != CHAR_RETURN) begin
               if (tally_in >= limit_in) begin
                  if (bsv_in) begin
                     res[n] = make_line(start_in, vebs_in, vcbs_in);
                     n = n + 1'b1;
                     lines_in = lines_in + 1'b1;
                     if (seg == p && blank) begin
                        go = 1'b0;
                        if (lines_in >= LINE_LIMIT) begin
                           cons_in = p_next;
                           phase_in = PH_DONE_BLANKS;
                        end else begin
                           phase_in = PH_SKIP;
                        end
                     end else if (lines_in >= LINE_LIMIT) begin
                        go = 1'b0;
                        phase_in = PH_DONE;
                        cons_in = seg;
                        cut_in = 1'b1;
                     end else begin
                        start_in = seg;
                        tally_in = cas_in;
                        bsv_in = 1'b0;
                        if (lve_in > seg) begin
                           lvc_in = cas_in;
                        end else begin
                           lve_in = seg;
                           lvc_in = '0;
                        end
                     end
                  end else begin
                     res[n] = make_line(start_in, lve_in, lvc_in);
                     n = n + 1'b1;
                     lines_in = lines_in + 1'b1;
                     if (lines_in >= LINE_LIMIT) begin
                        go = 1'b0;
                        phase_in = PH_DONE;
                        cons_in = p;
                        cut_in = 1'b1;
                     end else if (blank) begin
                        go = 1'b0;
                        phase_in = PH_SKIP;
                     end else begin
                        phase_in = PH_LINE;
                        start_in = p;
                        tally_in = '0;
                        bsv_in = 1'b0;
                        cas_in = '0;
                        lve_in = p;
                        lvc_in = '0;
                     end
                  end
               end
               if (go) begin
                  tally_in = tally_in + 1'b1;
                  if (blank) begin
                     vebs_in = lve_in;
                     vcbs_in = lvc_in;
                     bsi_in = p;
                     bsv_in = 1'b1;
                     cas_in = '0;
                  end else begin
                     cas_in = cas_in + 1'b1;
                     lve_in = p_next;
                     lvc_in = tally_in;
                  end
               end
            end
         end
         pos_in = p_next;
      end

      if (req_data.final_byte) begin
         if (phase_in == PH_LINE) begin
            res[n] = make_line(start_in, lve_in, lvc_in);
            n = n + 1'b1;
            lines_in = lines_in + 1'b1;
            cons_in = pos_in;
         end else if (phase_in == PH_SKIP) begin
            cons_in = pos_in;
         end
         summ.record_kind = KIND_SUMMARY;
         summ.taken_bytes = CONSUMED_W'(cons_in);
         summ.was_truncated = cut_in;
         summ.lines_made = LINES_W'(lines_in);
         res[n] = summ;
         n = n + 1'b1;
         limit_in = COLS_W'(1);
         pos_in = '0;
         phase_in = PH_SKIP;
         start_in = '0;
         tally_in = '0;
         bsi_in = '0;
         bsv_in = 1'b0;
         cas_in = '0;
         vebs_in = '0;
         vcbs_in = '0;
         lve_in = '0;
         lvc_in = '0;
         lines_in = '0;
         cons_in = '0;
         cut_in = 1'b0;
      end

      for (int i = 0; i < RESULTS_MAX; i++) begin
         res[i].run_end = (n != 2'd0) && (2'(i) == n - 1'b1);
      end

      step.count = n;
      step.item = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_columns_ff <= MAX_COLUMNS_RESET;
      end else if (csr_we) begin
         max_columns_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= COLS_W'(1);
         pos_ff <= '0;
         phase_ff <= PH_SKIP;
         start_ff <= '0;
         tally_ff <= '0;
         bsi_ff <= '0;
         bsv_ff <= 1'b0;
         cas_ff <= '0;
         vebs_ff <= '0;
         vcbs_ff <= '0;
         lve_ff <= '0;
         lvc_ff <= '0;
         lines_ff <= '0;
         cons_ff <= '0;
         cut_ff <= 1'b0;
      end else if (beat) begin
         limit_ff <= limit_in;
         pos_ff <= pos_in;
         phase_ff <= phase_in;
         start_ff <= start_in;
         tally_ff <= tally_in;
         bsi_ff <= bsi_in;
         bsv_ff <= bsv_in;
         cas_ff <= cas_in;
         vebs_ff <= vebs_in;
         vcbs_ff <= vcbs_in;
         lve_ff <= lve_in;
         lvc_ff <= lvc_in;
         lines_ff <= lines_in;
         cons_ff <= cons_in;
         cut_ff <= cut_in;
      end
   end

   assign status.pos_zero = (pos_ff == '0);

endmodule

`default_nettype wire

/* hw/rtl/cglw_rsp_fifo.sv */
// result queue: takes up to three results per cycle, hands out one per pop
// depends on cglw_pkg
`default_nettype none

module cglw_rsp_fifo
   import cglw_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire step_type  step,
   output logic           rsp_valid,
   input  wire logic      rsp_ready,
   output rsp_type        rsp_data,
   output fifo_status_type status
);

   rsp_type entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ff, wr_in;
   logic [FIFO_PTR_W-1:0]  rd_ff, rd_in;
   logic [FIFO_FILL_W-1:0] fill_ff, fill_in;
   logic [FIFO_FILL_W-1:0] push_count;
   logic                   pop;

   assign push_count = push ? FIFO_FILL_W'(step.count) : '0;
   assign pop = rsp_valid && rsp_ready;
   assign wr_in = wr_ff + FIFO_PTR_W'(push_count);
   assign rd_in = rd_ff + FIFO_PTR_W'(pop);
   assign fill_in = fill_ff + push_count - FIFO_FILL_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < RESULTS_MAX; k++) begin
         if (push && (2'(k) < step.count)) begin
            entry_ff[wr_ff + FIFO_PTR_W'(k)] <= step.item[k];
         end
      end
   end

   assign rsp_valid = (fill_ff != '0);
   assign rsp_data = entry_ff[rd_ff];
   assign status.fill = fill_ff;
   assign status.room = (fill_ff <= FIFO_FILL_W'(FIFO_DEPTH - RESULTS_MAX));

endmodule

`default_nettype wire

/* hw/rtl/caption_greedy_line_wrap_top.sv */
// caption greedy line wrapper top level, depends on cglw_pkg, cglw_core, cglw_rsp_fifo
// latency: a byte's first result is offered the cycle after its beat if the queue is empty
// throughput: one byte per cycle while each byte yields at most one result and results
//   are taken as offered; a byte with two or three results holds ready low until the
//   four-entry result queue has three free slots again
// reset: synchronous, clears the scan state and queue, column limit back to 40
`default_nettype none

module caption_greedy_line_wrap_top
   import cglw_pkg::*;
#(
   parameter int MAX_LINES = DEFAULT_MAX_LINES,
   parameter int MAX_TEXT = DEFAULT_MAX_TEXT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_we,
   input  wire logic [COLS_W-1:0] csr_wdata
);

   step_type        step;
   core_status_type core_status;
   fifo_status_type fifo_status;
   logic            beat_in;

   assign req_ready = fifo_status.room;
   assign beat_in = req_valid && req_ready;

   cglw_core #(
      .MAX_LINES(MAX_LINES),
      .MAX_TEXT(MAX_TEXT)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .beat(beat_in),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .step(step),
      .status(core_status)
   );

   cglw_rsp_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push(beat_in),
      .step(step),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .status(fifo_status)
   );

   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      beat_in && req_data.final_byte |-> step.count != 2'd0)
      else $error("final byte produced no result");

   a_final_clears_pos: assert property (@(posedge clock) disable iff (reset)
      beat_in && req_data.final_byte |=> core_status.pos_zero)
      else $error("caption state not cleared after final byte");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.fill <= FIFO_FILL_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   a_stall_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> fifo_status.fill >= $past(fifo_status.fill))
      else $error("result dropped while stalled");

endmodule

`default_nettype wire
